/* rtl/core/assert_macros.svh */
// assertion macros used by the rtl modules
// no dependencies; included inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant checked at every clock edge outside reset
`define CHK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/knn_pkg.sv */
// knn predictor package: sizes, command and status codes, distance kinds, register indices, sequencer states
// no dependencies
`timescale 1ns / 1ps

package knn_pkg;

  localparam int MAX_ROWS = 1024;
  localparam int FEATURES = 16;
  localparam int MAX_K    = 16;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int RT_W    = $clog2(MAX_ROWS + 1);
  localparam int FEAT_W  = $clog2(FEATURES);
  localparam int FP_W    = $clog2(FEATURES + 1);
  localparam int K_W     = $clog2(MAX_K);
  localparam int KC_W    = $clog2(MAX_K + 1);
  localparam int ADDR_W  = ROW_W + FEAT_W;
  localparam int LSUM_W  = 16 + KC_W;
  localparam int DIV_W   = LSUM_W - 1;
  localparam int DCNT_W  = $clog2(DIV_W);
  localparam int CFG_W   = 5;
  localparam int CIDX_W  = 2;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_TRAIN = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FEWER = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] DIST_MANHATTAN = 2'd1;
  localparam logic [1:0] DIST_MINKOWSKI = 2'd2;

  localparam logic [CIDX_W-1:0] REG_NEIGHBORS = 2'd0;
  localparam logic [CIDX_W-1:0] REG_MODE      = 2'd1;
  localparam logic [CIDX_W-1:0] REG_KIND      = 2'd2;
  localparam logic [CIDX_W-1:0] REG_ORDER     = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_RD,
    ST_DIFF,
    ST_POW,
    ST_ACC,
    ST_CHK,
    ST_INS,
    ST_LA,
    ST_LB,
    ST_DSET,
    ST_DIV,
    ST_VI,
    ST_VJ,
    ST_VC,
    ST_DONE
  } state_e;

endpackage

/* rtl/core/knn_predictor.sv */
// knn predictor top level: training store, distance scan, k-best list, vote and mean
// depends on knn_pkg and assert_macros.svh
`timescale 1ns / 1ps

// a feature request that does not end a row is taken in idle, which it does not leave (ready stays high)
// training row end: unless the store is full, the remaining feature positions are zero-filled, one store write each
// query row end: per stored row and feature a read, a difference, e - 1 multiplications through the shared multiplier
//   (e = 1 manhattan, 2 euclidean, p minkowski) and an accumulate, then a k-best check and insertion,
//   then the label loads, either a divide or a vote, and the output register
// reset: registers to k 3, vote, euclidean, order 2; store empty; no clearing pass
module knn_predictor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [knn_pkg::CIDX_W-1:0]    cfg_idx_i,
  input  logic [knn_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic signed [15:0]            feature_value_i,
  input  logic signed [15:0]            target_label_i,
  input  logic                          row_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            prediction_o,
  output logic [1:0]                    status_o
);
  import knn_pkg::*;

  `include "assert_macros.svh"

  state_e state_q, state_d;

  // configuration registers
  logic [4:0] k_cfg_q;
  logic       mode_q;
  logic [1:0] kind_q;
  logic [3:0] ord_q;

  // row assembly
  logic [FP_W-1:0]   fp_q;
  logic [RT_W-1:0]   row_total_q;
  logic signed [15:0] qbuf_q [FEATURES];
  logic [ROW_W-1:0]  fill_row_q;
  logic [FP_W-1:0]   fill_pos_q;

  // memories: training features and labels
  logic [15:0] feat_mem [MAX_ROWS*FEATURES];
  logic [15:0] lab_mem  [MAX_ROWS];
  logic signed [15:0] feat_rd_q, lab_rd_q;

  // scan datapath
  logic [RT_W-1:0]   row_q;
  logic [FEAT_W-1:0] f_q;
  logic [15:0]       base_q;
  logic [63:0]       pw_q, sum_q, dist_q;
  logic              sat_q;
  logic [3:0]        cnt_q;

  // k-best list
  logic [KC_W-1:0]   m_q, filled_q;
  logic [K_W-1:0]    j_q, n_q;
  logic [63:0]       best_d_q [MAX_K];
  logic [ROW_W-1:0]  best_i_q [MAX_K];

  // label stage, divider and vote
  logic signed [15:0]       lab_q [MAX_K];
  logic signed [LSUM_W-1:0] lsum_q;
  logic [DIV_W-1:0]         quo_q;
  logic [KC_W:0]            rem_q;
  logic [DCNT_W-1:0]        dcnt_q;
  logic                     neg_q;
  logic signed [15:0]       cur_q, bl_q;
  logic [KC_W-1:0]          votes_q, bv_q;

  // result and output register
  logic signed [15:0] res_pred_q, out_pred_q;
  logic [1:0]         res_stat_q, out_stat_q;
  logic               out_valid_q;

  // ---------------------------------------------------------------------------
  // combinational helpers
  // ---------------------------------------------------------------------------
  logic              acc;
  logic              full;
  logic [FP_W-1:0]   fp_nx;
  logic [KC_W-1:0]   k_eff, m_nx;
  logic [3:0]        exp_m1;
  logic [K_W-1:0]    m_last, bsel, lsel;
  logic              row_last;
  logic              out_free;

  assign acc      = in_valid_i && in_ready_o;
  assign full     = row_total_q >= RT_W'(MAX_ROWS);
  assign fp_nx    = (fp_q < FP_W'(FEATURES)) ? fp_q + FP_W'(1) : fp_q;
  assign m_last   = K_W'(m_q - KC_W'(1));
  assign row_last = (row_q + RT_W'(1)) == row_total_q;
  assign out_free = !out_valid_q || out_ready_i;

  // k of zero acts as one, oversized k is clamped
  always_comb begin
    if (k_cfg_q == 5'd0) begin
      k_eff = KC_W'(1);
    end else if (32'(k_cfg_q) > MAX_K) begin
      k_eff = KC_W'(MAX_K);
    end else begin
      k_eff = KC_W'(k_cfg_q);
    end
    m_nx = (row_total_q < RT_W'(k_eff)) ? KC_W'(row_total_q) : k_eff;
  end

  // number of multiplications after the first factor
  always_comb begin
    case (kind_q)
      DIST_MANHATTAN: exp_m1 = 4'd0;
      DIST_MINKOWSKI: exp_m1 = (ord_q == 4'd0) ? 4'd0 : ord_q - 4'd1;
      default:        exp_m1 = 4'd1;
    endcase
  end

  // feature difference and its magnitude
  logic signed [16:0] diff;
  logic [15:0]        mag;
  assign diff = {qbuf_q[f_q][15], qbuf_q[f_q]} - {feat_rd_q[15], feat_rd_q};
  assign mag  = diff[16] ? 16'(-diff) : diff[15:0];

  // shared multiplier of the power unit, one product per cycle
  logic [79:0] prod;
  assign prod = pw_q * base_q;

  // saturating accumulate
  logic [64:0] acc_sum;
  logic [63:0] sum_sat;
  assign acc_sum = {1'b0, sum_q} + {1'b0, pw_q};
  assign sum_sat = acc_sum[64] ? '1 : acc_sum[63:0];

  // divider step
  logic [KC_W:0]    rem_sh;
  logic             q_bit;
  logic [DIV_W-1:0] quo_nx;
  assign rem_sh = {rem_q[KC_W-1:0], quo_q[DIV_W-1]};
  assign q_bit  = rem_sh >= {1'b0, m_q};
  assign quo_nx = {quo_q[DIV_W-2:0], q_bit};

  // vote update
  logic              vote_upd;
  logic signed [15:0] bl_nx;
  assign vote_upd = (votes_q > bv_q) || ((votes_q == bv_q) && (cur_q < bl_q));
  assign bl_nx    = vote_upd ? cur_q : bl_q;

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && row_end_i) begin
          if (cmd_i == CMD_TRAIN) begin
            state_d = (!full && fp_nx < FP_W'(FEATURES)) ? ST_FILL : ST_DONE;
          end else if (cmd_i == CMD_QUERY) begin
            state_d = (m_nx == '0) ? ST_DONE : ST_RD;
          end
        end
      end
      ST_FILL: begin
        if (fill_pos_q == FP_W'(FEATURES - 1)) state_d = ST_DONE;
      end
      ST_RD:   state_d = ST_DIFF;
      ST_DIFF: state_d = (exp_m1 == 4'd0) ? ST_ACC : ST_POW;
      ST_POW: begin
        if (cnt_q == 4'd1) state_d = ST_ACC;
      end
      ST_ACC: begin
        if (f_q == FEAT_W'(FEATURES - 1)) state_d = ST_CHK;
        else state_d = ST_RD;
      end
      ST_CHK: begin
        if (filled_q < m_q || dist_q < best_d_q[bsel]) begin
          state_d = ST_INS;
        end else begin
          state_d = row_last ? ST_LA : ST_RD;
        end
      end
      ST_INS: begin
        if (!(j_q != '0 && best_d_q[bsel] > dist_q)) begin
          state_d = row_last ? ST_LA : ST_RD;
        end
      end
      ST_LA: state_d = ST_LB;
      ST_LB: begin
        if (n_q == m_last) state_d = mode_q ? ST_DSET : ST_VI;
        else state_d = ST_LA;
      end
      ST_DSET: state_d = ST_DIV;
      ST_DIV: begin
        if (dcnt_q == '0) state_d = ST_DONE;
      end
      ST_VI: state_d = ST_VJ;
      ST_VJ: begin
        if (j_q == m_last) state_d = ST_VC;
      end
      ST_VC: state_d = (n_q == m_last) ? ST_DONE : ST_VI;
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs: handshake and read selects
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    bsel       = K_W'(j_q - K_W'(1));
    lsel       = j_q;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_CHK:  bsel       = m_last;
      ST_VI:   lsel       = n_q;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // training store write port: feature requests and zero fill share it
  // ---------------------------------------------------------------------------
  logic              fw_en;
  logic [ADDR_W-1:0] fw_addr;
  logic [15:0]       fw_data;

  always_comb begin
    fw_en   = 1'b0;
    fw_addr = {row_total_q[ROW_W-1:0], fp_q[FEAT_W-1:0]};
    fw_data = feature_value_i;
    if (state_q == ST_FILL) begin
      fw_en   = 1'b1;
      fw_addr = {fill_row_q, fill_pos_q[FEAT_W-1:0]};
      fw_data = '0;
    end else if (acc && cmd_i == CMD_TRAIN && fp_q < FP_W'(FEATURES) && !full) begin
      fw_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fw_en) feat_mem[fw_addr] <= fw_data;
    if (state_q == ST_RD) feat_rd_q <= feat_mem[{row_q[ROW_W-1:0], f_q}];
  end

  always_ff @(posedge clk_i) begin
    if (acc && cmd_i == CMD_TRAIN && row_end_i && !full) begin
      lab_mem[row_total_q[ROW_W-1:0]] <= target_label_i;
    end
    if (state_q == ST_LA) lab_rd_q <= lab_mem[best_i_q[n_q]];
  end

  // query buffer: written at the row position, cleared past it at row end
  always_ff @(posedge clk_i) begin
    if (acc && cmd_i == CMD_QUERY) begin
      for (int f = 0; f < FEATURES; f++) begin
        if (FP_W'(f) == fp_q) begin
          qbuf_q[f] <= feature_value_i;
        end else if (row_end_i && FP_W'(f) > fp_q) begin
          qbuf_q[f] <= '0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_cfg_q     <= 5'd3;
      mode_q      <= 1'b0;
      kind_q      <= 2'd0;
      ord_q       <= 4'd2;
      fp_q        <= '0;
      row_total_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_NEIGHBORS: k_cfg_q <= cfg_data_i;
          REG_MODE:      mode_q  <= cfg_data_i[0];
          REG_KIND:      kind_q  <= cfg_data_i[1:0];
          REG_ORDER:     ord_q   <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (acc) begin
        case (cmd_i)
          CMD_CLEAR: begin
            row_total_q <= '0;
            fp_q        <= '0;
          end
          CMD_TRAIN: begin
            fp_q <= row_end_i ? '0 : fp_nx;
            if (row_end_i && !full) row_total_q <= row_total_q + RT_W'(1);
          end
          CMD_QUERY: fp_q <= row_end_i ? '0 : fp_nx;
          default: ;
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (acc && row_end_i) begin
          res_pred_q <= '0;
          if (cmd_i == CMD_TRAIN) begin
            res_stat_q <= full ? STAT_FULL : STAT_OK;
            fill_row_q <= row_total_q[ROW_W-1:0];
            fill_pos_q <= fp_nx;
          end else begin
            res_stat_q <= (row_total_q < RT_W'(k_eff)) ? STAT_FEWER : STAT_OK;
            m_q        <= m_nx;
            filled_q   <= '0;
            row_q      <= '0;
            f_q        <= '0;
            sum_q      <= '0;
          end
        end
      end
      ST_FILL: fill_pos_q <= fill_pos_q + FP_W'(1);
      ST_DIFF: begin
        base_q <= mag;
        pw_q   <= 64'(mag);
        sat_q  <= 1'b0;
        cnt_q  <= exp_m1;
      end
      ST_POW: begin
        cnt_q <= cnt_q - 4'd1;
        if (!sat_q) begin
          if (prod[79:64] != '0) begin
            pw_q  <= '1;
            sat_q <= 1'b1;
          end else begin
            pw_q <= prod[63:0];
          end
        end
      end
      ST_ACC: begin
        sum_q  <= sum_sat;
        dist_q <= sum_sat;
        f_q    <= f_q + FEAT_W'(1);
      end
      ST_CHK: begin
        if (filled_q < m_q) begin
          j_q      <= K_W'(filled_q);
          filled_q <= filled_q + KC_W'(1);
        end else if (dist_q < best_d_q[bsel]) begin
          j_q <= m_last;
        end else begin
          row_q  <= row_q + RT_W'(1);
          sum_q  <= '0;
          n_q    <= '0;
          lsum_q <= '0;
        end
      end
      ST_INS: begin
        if (j_q != '0 && best_d_q[bsel] > dist_q) begin
          best_d_q[j_q] <= best_d_q[bsel];
          best_i_q[j_q] <= best_i_q[bsel];
          j_q           <= j_q - K_W'(1);
        end else begin
          best_d_q[j_q] <= dist_q;
          best_i_q[j_q] <= row_q[ROW_W-1:0];
          row_q         <= row_q + RT_W'(1);
          sum_q         <= '0;
          n_q           <= '0;
          lsum_q        <= '0;
        end
      end
      ST_LB: begin
        lab_q[n_q] <= lab_rd_q;
        lsum_q     <= lsum_q + LSUM_W'(lab_rd_q);
        if (n_q == m_last) begin
          n_q  <= '0;
          bv_q <= '0;
          bl_q <= '0;
        end else begin
          n_q <= n_q + K_W'(1);
        end
      end
      ST_DSET: begin
        neg_q  <= lsum_q[LSUM_W-1];
        quo_q  <= lsum_q[LSUM_W-1] ? DIV_W'(-lsum_q) : lsum_q[DIV_W-1:0];
        rem_q  <= '0;
        dcnt_q <= DCNT_W'(DIV_W - 1);
      end
      ST_DIV: begin
        rem_q  <= q_bit ? rem_sh - {1'b0, m_q} : rem_sh;
        quo_q  <= quo_nx;
        dcnt_q <= dcnt_q - DCNT_W'(1);
        if (dcnt_q == '0) begin
          res_pred_q <= neg_q ? 16'(-quo_nx[15:0]) : quo_nx[15:0];
        end
      end
      ST_VI: begin
        cur_q   <= lab_q[lsel];
        votes_q <= '0;
        j_q     <= '0;
      end
      ST_VJ: begin
        if (lab_q[lsel] == cur_q) votes_q <= votes_q + KC_W'(1);
        j_q <= j_q + K_W'(1);
      end
      ST_VC: begin
        if (vote_upd) begin
          bv_q <= votes_q;
          bl_q <= cur_q;
        end
        if (n_q == m_last) res_pred_q <= bl_nx;
        n_q <= n_q + K_W'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_pred_q <= res_pred_q;
          out_stat_q <= res_stat_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign prediction_o = out_pred_q;
  assign status_o     = out_stat_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `CHK_ALWAYS(a_fp_range, fp_q <= FP_W'(FEATURES), "row position past feature count")
  `CHK_ALWAYS(a_rows_range, row_total_q <= RT_W'(MAX_ROWS), "row count past store size")
  `CHK_IMPLY(a_ins_slot, state_q == ST_INS, K_W'(j_q) < m_q && filled_q <= m_q, "insert slot out of list")
  `CHK_NEXT(a_scan_busy, state_q == ST_RD, !in_ready_o, "request taken during scan")

endmodule

/* tb/sv/knn_predictor_tb.sv */
// self-checking testbench for the knn predictor: directed rows, a full-store run, then random train/query traffic
// depends on knn_pkg and the knn_predictor rtl; predicts answers with its own knn scan, typed directed rows give theirs
`timescale 1ns / 1ps

module knn_predictor_tb;
  import knn_pkg::*;

  localparam int          WATCHDOG_LIMIT = 400000;
  localparam int          RANDOM_ITEMS   = 450;
  localparam int          ROWS_PER_PHASE = 8;
  localparam int          ROW_CAP        = 20;
  localparam logic [63:0] DIST_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [1:0]  CMD_NOP        = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CIDX_W-1:0]    cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [1:0]           cmd_i = CMD_CLEAR;
  logic signed [15:0]   feature_value_i = '0;
  logic signed [15:0]   target_label_i = '0;
  logic                 row_end_i = 1'b0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic signed [15:0]   prediction_o;
  logic [1:0]           status_o;

  knn_predictor i_dut (.*);

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor state: own copy of the store, the query row and the registers
  // ---------------------------------------------------------------------------
  logic [15:0] store_feat [MAX_ROWS][FEATURES];
  logic [15:0] store_label [MAX_ROWS];
  int          stored_rows;
  logic [15:0] query_row [FEATURES];
  int          row_pos;
  int          k_reg, mode_reg, kind_reg, order_reg;

  typedef struct packed {
    logic [15:0] pred;
    logic [1:0]  stat;
  } answer_t;

  answer_t pending_answers[$];

  int errors = 0;
  int n_items = 0, n_queries = 0, n_train_rows = 0, n_dropped = 0, n_phases = 0;
  int burst_left = 0;

  // saturating |d|^p
  function automatic logic [63:0] power_sat(logic [63:0] b, int p);
    logic [63:0] r;
    r = 1;
    for (int i = 0; i < p; i++) begin
      if (b != 0 && r > DIST_MAX / b) return DIST_MAX;
      r = r * b;
    end
    return r;
  endfunction

  // distance of query_row to stored row r, root dropped, saturating sum
  function automatic logic [63:0] row_dist(int r);
    logic [63:0] acc, a, term;
    int d, p;
    acc = 0;
    p = (order_reg == 0) ? 1 : order_reg;
    for (int f = 0; f < FEATURES; f++) begin
      d = int'($signed(query_row[f])) - int'($signed(store_feat[r][f]));
      a = (d < 0) ? -d : d;
      if (kind_reg == DIST_MANHATTAN) term = a;
      else if (kind_reg == DIST_MINKOWSKI) term = power_sat(a, p);
      else term = a * a;
      acc = (term > ~acc) ? DIST_MAX : acc + term;
    end
    return acc;
  endfunction

  // k-best scan then vote or mean
  function automatic answer_t classify_query();
    answer_t     ans;
    logic [63:0] best_d [MAX_K];
    int          best_i [MAX_K];
    logic [63:0] cand_d;
    int          k, m, filled, j, lab, votes, best_lab, best_votes;
    longint      sum;
    k = (k_reg == 0) ? 1 : k_reg;
    if (k > MAX_K) k = MAX_K;
    m = (stored_rows < k) ? stored_rows : k;
    ans.stat = (stored_rows < k) ? STAT_FEWER : STAT_OK;
    ans.pred = '0;
    if (m == 0) return ans;
    for (int i = 0; i < MAX_K; i++) begin
      best_d[i] = DIST_MAX;
      best_i[i] = 0;
    end
    filled = 0;
    for (int r = 0; r < stored_rows; r++) begin
      cand_d = row_dist(r);
      if (filled < m) begin
        j = filled;
        filled++;
      end else if (cand_d < best_d[m-1]) begin
        j = m - 1;
      end else begin
        continue;
      end
      // strict compare keeps the lower row index ahead on equal distance
      while (j > 0 && best_d[j-1] > cand_d) begin
        best_d[j] = best_d[j-1];
        best_i[j] = best_i[j-1];
        j--;
      end
      best_d[j] = cand_d;
      best_i[j] = r;
    end
    if (mode_reg != 0) begin
      sum = 0;
      for (int i = 0; i < m; i++) sum += longint'($signed(store_label[best_i[i]]));
      ans.pred = 16'(sum / m);
    end else begin
      best_lab = 0;
      best_votes = 0;
      for (int i = 0; i < m; i++) begin
        lab = int'($signed(store_label[best_i[i]]));
        votes = 0;
        for (int q = 0; q < m; q++)
          if (int'($signed(store_label[best_i[q]])) == lab) votes++;
        // vote tie goes to the smaller label
        if (votes > best_votes || (votes == best_votes && lab < best_lab)) begin
          best_votes = votes;
          best_lab = lab;
        end
      end
      ans.pred = 16'(best_lab);
    end
    return ans;
  endfunction

  // apply one accepted request to the predictor; returns 1 when it yields an answer
  function automatic bit apply_request(logic [1:0] c, logic [15:0] fv, logic [15:0] lab,
                                       logic e, output answer_t ans);
    bit full;
    ans = '0;
    if (c == CMD_CLEAR) begin
      stored_rows = 0;
      row_pos = 0;
      return 0;
    end
    if (c == CMD_NOP) return 0;
    if (c == CMD_TRAIN) begin
      full = stored_rows >= MAX_ROWS;
      if (row_pos < FEATURES) begin
        if (!full) store_feat[stored_rows][row_pos] = fv;
        row_pos++;
      end
      if (!e) return 0;
      if (!full) begin
        for (int f = row_pos; f < FEATURES; f++) store_feat[stored_rows][f] = '0;
        store_label[stored_rows] = lab;
        stored_rows++;
        n_train_rows++;
      end else begin
        n_dropped++;
      end
      ans.stat = full ? STAT_FULL : STAT_OK;
      row_pos = 0;
      return 1;
    end
    if (row_pos < FEATURES) begin
      query_row[row_pos] = fv;
      row_pos++;
    end
    if (!e) return 0;
    for (int f = row_pos; f < FEATURES; f++) query_row[f] = '0;
    row_pos = 0;
    n_queries++;
    ans = classify_query();
    return 1;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length, random gaps in between
  // ---------------------------------------------------------------------------
  task automatic send(logic [1:0] c, logic [15:0] fv, logic [15:0] lab, logic e,
                      bit typed = 0, logic [15:0] typed_pred = '0,
                      logic [1:0] typed_stat = STAT_OK);
    answer_t ans;
    int      gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    cmd_i = c;
    feature_value_i = fv;
    target_label_i = lab;
    row_end_i = e;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    n_items++;
    if (apply_request(c, fv, lab, e, ans)) begin
      if (typed) begin
        ans.pred = typed_pred;
        ans.stat = typed_stat;
      end
      pending_answers.push_back(ans);
    end
    @(negedge clk_i);
  endtask

  // block idle: all answers in, then a margin for a trailing clear
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, int val);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_NEIGHBORS: k_reg = val & 31;
      REG_MODE:      mode_reg = val & 1;
      REG_KIND:      kind_reg = val & 3;
      default:       order_reg = val & 15;
    endcase
  endtask

  task automatic configure(int k, int mode, int kind, int order);
    drain();
    cfg_write(REG_NEIGHBORS, k);
    cfg_write(REG_MODE, mode);
    cfg_write(REG_KIND, kind);
    cfg_write(REG_ORDER, order);
    n_phases++;
  endtask

  // ---------------------------------------------------------------------------
  // answer checker and receiver stall pattern
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    answer_t exp_ans;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected answer pred=%h status=%0d", $time, prediction_o, status_o);
        errors++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (prediction_o !== exp_ans.pred) begin
          $display("%0t: prediction expected %h actual %h", $time, exp_ans.pred, prediction_o);
          errors++;
        end
        if (status_o !== exp_ans.stat) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_ans.stat, status_o);
          errors++;
        end
      end
    end
  end

  // receiver: stretches of always-ready, light and heavy stalling
  int ready_pct = 100;
  int ready_span = 0;
  always @(negedge clk_i) begin
    if (ready_span == 0) begin
      case ($urandom_range(0, 2))
        0:       ready_pct = 100;
        1:       ready_pct = 70;
        default: ready_pct = 25;
      endcase
      ready_span = $urandom_range(20, 300);
    end
    ready_span--;
    out_ready_i = ($urandom_range(1, 100) <= ready_pct);
  end

  // watchdog on cycles without any accepted request or answer
  int quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d answers outstanding", $time,
               pending_answers.size());
      $display("knn_predictor_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed rows
  // ---------------------------------------------------------------------------
  typedef struct {
    logic [1:0]  c;
    logic [15:0] fv;
    logic [15:0] lab;
    logic        e;
    int          reps;   // copies sent with row end low before this one
    bit          typed;
    logic [15:0] tpred;
    logic [1:0]  tstat;
  } stim_row_t;

  stim_row_t stim_rows[] = '{
    // empty store: nothing to vote on
    '{CMD_QUERY, 16'h7FFF, 16'h0000, 1'b1, 0, 1, 16'h0000, STAT_FEWER},
    '{CMD_NOP,   16'hFFFF, 16'hFFFF, 1'b1, 0, 0, 16'h0000, STAT_OK},
    '{CMD_TRAIN, 16'h8000, 16'h0000, 1'b0, 0, 0, 16'h0000, STAT_OK},
    '{CMD_TRAIN, 16'h7FFF, 16'h0000, 1'b0, 0, 0, 16'h0000, STAT_OK},
    '{CMD_TRAIN, 16'h0000, 16'h7FFF, 1'b1, 0, 1, 16'h0000, STAT_OK},
    '{CMD_TRAIN, 16'hFFFF, 16'h8000, 1'b1, 0, 1, 16'h0000, STAT_OK},
    // two rows stored, k is 3
    '{CMD_QUERY, 16'h0001, 16'h0000, 1'b1, 0, 0, 16'h0000, STAT_OK},
    // mixed row: query feature then a training end
    '{CMD_QUERY, 16'h1234, 16'h0000, 1'b0, 0, 0, 16'h0000, STAT_OK},
    '{CMD_TRAIN, 16'h00FF, 16'h0100, 1'b1, 0, 1, 16'h0000, STAT_OK},
    // long row: features past the row width are ignored
    '{CMD_TRAIN, 16'h0100, 16'hFF00, 1'b1, 17, 1, 16'h0000, STAT_OK},
    '{CMD_QUERY, 16'h0100, 16'h0000, 1'b1, 0, 0, 16'h0000, STAT_OK},
    '{CMD_CLEAR, 16'h5555, 16'hAAAA, 1'b1, 0, 0, 16'h0000, STAT_OK},
    '{CMD_QUERY, 16'hAAAA, 16'h0000, 1'b1, 0, 1, 16'h0000, STAT_FEWER}
  };

  // ---------------------------------------------------------------------------
  // random rows: clustered content with labels from a few classes
  // ---------------------------------------------------------------------------
  logic [15:0] centers [4][FEATURES];

  function automatic logic [15:0] pick_feature(int cls, int f);
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    return centers[cls][f] + 16'($signed($urandom_range(0, 128)) - 64);
  endfunction

  task automatic random_row(logic [1:0] c);
    int          cls, len;
    logic [15:0] lab;
    logic [1:0]  cc;
    cls = $urandom_range(0, 3);
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, FEATURES + 4) : FEATURES;
    lab = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'(cls * 256 - 256);
    for (int f = 0; f < len; f++) begin
      cc = c;
      if (f != len - 1 && $urandom_range(0, 19) == 0)
        cc = (c == CMD_TRAIN) ? CMD_QUERY : CMD_TRAIN;
      if ($urandom_range(0, 39) == 0) send(CMD_NOP, 16'($urandom), 16'($urandom), 1'($urandom));
      send(cc, pick_feature(cls, f), lab, f == len - 1);
    end
  endtask

  int start_items;

  initial begin
    stored_rows = 0;
    row_pos = 0;
    k_reg = 3;
    mode_reg = 0;
    kind_reg = 0;
    order_reg = 2;
    for (int c = 0; c < 4; c++)
      for (int f = 0; f < FEATURES; f++) centers[c][f] = 16'($urandom_range(0, 4095)) - 16'd2048;

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed rows under reset values of the registers
    foreach (stim_rows[i]) begin
      repeat (stim_rows[i].reps)
        send(stim_rows[i].c, stim_rows[i].fv, stim_rows[i].lab, 1'b0);
      send(stim_rows[i].c, stim_rows[i].fv, stim_rows[i].lab, stim_rows[i].e,
           stim_rows[i].typed, stim_rows[i].tpred, stim_rows[i].tstat);
    end

    // fill the store to the brim, then overflow it and query the full set
    configure(3, 0, DIST_MANHATTAN, 1);
    send(CMD_CLEAR, '0, '0, 1'b0);
    for (int r = 0; r < MAX_ROWS; r++)
      send(CMD_TRAIN, 16'($urandom), 16'($urandom_range(0, 3) * 256), 1'b1);
    send(CMD_TRAIN, 16'h1111, 16'h2222, 1'b0);
    send(CMD_TRAIN, 16'h3333, 16'h4444, 1'b1, 1, 16'h0000, STAT_FULL);
    send(CMD_QUERY, 16'($urandom), '0, 1'b1);
    send(CMD_CLEAR, '0, '0, 1'b1);

    // random phases, the first few at the register extremes
    start_items = n_items;
    for (int ph = 0; n_items - start_items < RANDOM_ITEMS; ph++) begin
      case (ph)
        0:       configure(0, 0, 3, 0);
        1:       configure(16, 1, DIST_MINKOWSKI, 8);
        2:       configure(31, 1, DIST_MINKOWSKI, 15);
        3:       configure(1, 0, DIST_MANHATTAN, 1);
        default: configure($urandom_range(0, 7) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16),
                           $urandom_range(0, 1), $urandom_range(0, 3),
                           $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : $urandom_range(1, 4));
      endcase
      send(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom));
      for (int n = 0; n < ROWS_PER_PHASE; n++) begin
        if (stored_rows >= ROW_CAP || $urandom_range(0, 49) == 0)
          send(CMD_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom));
        random_row(($urandom_range(0, 2) == 0) ? CMD_QUERY : CMD_TRAIN);
        if (n_items - start_items >= RANDOM_ITEMS) break;
      end
    end

    drain();
    $display("covered %0d requests over %0d phases: %0d training rows, %0d dropped, %0d queries",
             n_items, n_phases, n_train_rows, n_dropped, n_queries);
    if (errors == 0) begin
      $display("knn_predictor_tb OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("knn_predictor_tb NOT OK");
    end
    $finish;
  end

endmodule

/* knn_predictor.f */
+incdir+rtl/core
rtl/core/knn_pkg.sv
rtl/core/knn_predictor.sv
tb/sv/knn_predictor_tb.sv
